// ===== design/esot_pkg.sv =====
`timescale 1ns / 1ps

package esot_pkg;

   // Fixed field widths of the register file and the result item.
   localparam int CFG_DATA_W   = 32;
   localparam int CFG_INDEX_W  = 3;
   localparam int COUNT_W      = 8;
   localparam int REASON_W     = 8;
   localparam int OUT_TIME_W   = 32;
   localparam int OPCODE_W     = 2;
   localparam int STATUS_W     = 3;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 80;

   typedef enum logic [OPCODE_W-1:0] {
      OP_START  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_RESCHED = 3'd0,
      ST_TRIG    = 3'd1,
      ST_DISARM  = 3'd2,
      ST_IGNORE  = 3'd3,
      ST_REPORT  = 3'd4
   } status_type;

   typedef enum logic [CFG_INDEX_W-1:0] {
      REG_START_TIME     = 3'd0,
      REG_SAMPLE_TIME    = 3'd1,
      REG_SAMPLE_COUNT   = 3'd2,
      REG_REST_TIME      = 3'd3,
      REG_TRIGGER_LEVEL  = 3'd4,
      REG_TRIGGER_REASON = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_REST = 3'b010,
      MODE_OVER = 3'b100
   } mode_type;

   typedef struct packed {
      logic [CFG_DATA_W-1:0] start_time;
      logic [CFG_DATA_W-1:0] sample_period;
      logic [COUNT_W-1:0]    sample_goal;
      logic [CFG_DATA_W-1:0] rest_period;
      logic                  trigger_level;
      logic [REASON_W-1:0]   trip_reason;
   } cfg_type;

   typedef struct packed {
      status_type            status;
      logic [OUT_TIME_W-1:0] wake_time;
      logic [REASON_W-1:0]   fired_reason;
      logic                  homing_flag;
      logic [OUT_TIME_W-1:0] wake_record;
      logic                  level_echo;
   } result_type;

endpackage

// ===== design/esot_csr.sv =====
`timescale 1ns / 1ps

module esot_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [esot_pkg::CFG_INDEX_W-1:0]   wr_index,
   input  logic [esot_pkg::CFG_DATA_W-1:0]    wr_data,
   output esot_pkg::cfg_type                  cfg
);
   import esot_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_START_TIME:     cfg_in.start_time     = wr_data;
            REG_SAMPLE_TIME:    cfg_in.sample_period  = wr_data;
            REG_SAMPLE_COUNT:   cfg_in.sample_goal    = wr_data[COUNT_W-1:0];
            REG_REST_TIME:      cfg_in.rest_period    = wr_data;
            REG_TRIGGER_LEVEL:  cfg_in.trigger_level  = wr_data[0];
            REG_TRIGGER_REASON: cfg_in.trip_reason    = wr_data[REASON_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/esot_core.sv =====
`timescale 1ns / 1ps

module esot_core #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  logic [esot_pkg::OPCODE_W-1:0]   opcode,
   input  logic                            pin_level,
   input  esot_pkg::cfg_type               cfg,
   output esot_pkg::result_type            result
);
   import esot_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [TIME_WIDTH-1:0]  wake_ff, wake_in;
   logic [TIME_WIDTH-1:0]  next_wake_ff, next_wake_in;
   logic [COUNT_W-1:0]     remain_ff, remain_in;
   logic                   homing_ff, homing_in;

   logic [TIME_WIDTH-1:0]  rest_sum;
   logic [TIME_WIDTH-1:0]  over_sum;
   logic [TIME_WIDTH-1:0]  start_clock;
   logic [COUNT_W-1:0]     count_dec;
   logic                   level_match;
   result_type             res;

   // Both candidate wake times come from the current wake clock.
   assign rest_sum    = wake_ff + TIME_WIDTH'(cfg.rest_period);
   assign over_sum    = wake_ff + TIME_WIDTH'(cfg.sample_period);
   assign start_clock = TIME_WIDTH'(cfg.start_time);
   assign count_dec   = remain_ff - COUNT_W'(1);
   assign level_match = (pin_level == cfg.trigger_level);

   always_comb begin
      mode_in      = mode_ff;
      wake_in      = wake_ff;
      next_wake_in = next_wake_ff;
      remain_in    = remain_ff;
      homing_in    = homing_ff;
      res          = '0;
      res.status   = ST_IGNORE;

      unique case (opcode)
         OP_START: begin
            wake_in = start_clock;
            if (cfg.sample_goal == '0) begin
               mode_in    = MODE_IDLE;
               homing_in  = 1'b0;
               res.status = ST_DISARM;
            end else begin
               mode_in       = MODE_REST;
               remain_in     = cfg.sample_goal;
               homing_in     = 1'b1;
               res.status    = ST_RESCHED;
               res.wake_time = OUT_TIME_W'(start_clock);
            end
         end
         OP_SAMPLE: begin
            if (mode_ff == MODE_REST && !level_match) begin
               wake_in       = rest_sum;
               res.status    = ST_RESCHED;
               res.wake_time = OUT_TIME_W'(rest_sum);
            end else if (mode_ff == MODE_OVER && !level_match) begin
               // Glitch: reload the count and fall back to rest polling.
               mode_in       = MODE_REST;
               wake_in       = next_wake_ff;
               remain_in     = cfg.sample_goal;
               res.status    = ST_RESCHED;
               res.wake_time = OUT_TIME_W'(next_wake_ff);
            end else if (mode_ff == MODE_REST || mode_ff == MODE_OVER) begin
               // Matching level: a rest-mode hit first records the next
               // rest wake time, then both modes take one oversample step.
               if (mode_ff == MODE_REST) begin
                  next_wake_in = rest_sum;
               end
               if (count_dec == '0) begin
                  mode_in          = MODE_IDLE;
                  res.status       = ST_TRIG;
                  res.fired_reason = cfg.trip_reason;
               end else begin
                  mode_in       = MODE_OVER;
                  remain_in     = count_dec;
                  wake_in       = over_sum;
                  res.status    = ST_RESCHED;
                  res.wake_time = OUT_TIME_W'(over_sum);
               end
            end
         end
         OP_QUERY: begin
            res.status      = ST_REPORT;
            res.homing_flag = homing_ff;
            res.wake_record = OUT_TIME_W'(next_wake_ff);
            res.level_echo  = pin_level;
         end
         default: begin
            res.status = ST_IGNORE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         wake_ff      <= '0;
         next_wake_ff <= '0;
         remain_ff    <= '0;
         homing_ff    <= 1'b0;
      end else if (step_en) begin
         mode_ff      <= mode_in;
         wake_ff      <= wake_in;
         next_wake_ff <= next_wake_in;
         remain_ff    <= remain_in;
         homing_ff    <= homing_in;
      end
   end

   assign result = res;

endmodule

// ===== design/endstop_oversample_trigger.sv =====
`timescale 1ns / 1ps

// Endstop oversampling trigger detector for homing. A start request arms the
// block from the configuration registers and schedules rest polling at
// start_time, or disarms it when sample_goal is zero; each timer sample
// request carries the pin level and gets back a response telling the timer
// when to sample next, that the trigger fired (with its reason), or that
// the sample was ignored. A query request reports the homing flag and the
// recorded next wake time. The block takes one request per clock cycle while
// responses are not stalled. An accepted request waits in the input
// register; once the result register is empty or being emptied, its response
// is loaded into the result register and offered. While a response waits,
// the input register can still take one request, then holds it and accepts
// no more until the result register frees up. The per-sample work is a
// level compare, an 8-bit decrement and a TIME_WIDTH-bit add, all done in
// the single logic stage between those two registers. Configuration writes
// are always accepted and must only be issued while no request is in flight.

module endstop_oversample_trigger #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,

   // Request channel.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] pin_level, [7:1] zero
   input  logic [esot_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] opcode
   input  logic [esot_pkg::OPCODE_W-1:0]        req_tuser,

   // Response channel.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] wake_time, [39:32] fired_reason, [40] homing_flag,
   // [72:41] wake_record, [73] level_echo, [79:74] zero
   output logic [esot_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [2:0] status
   output logic [esot_pkg::STATUS_W-1:0]        rsp_tuser,

   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [esot_pkg::CFG_INDEX_W-1:0]     csr_index,
   input  logic [esot_pkg::CFG_DATA_W-1:0]      csr_data
);
   import esot_pkg::*;

   cfg_type               cfg;
   result_type            step_result;

   // Input register: holds one accepted request until the logic stage runs.
   logic                  in_valid_ff, in_valid_in;
   logic [OPCODE_W-1:0]   in_opcode_ff;
   logic                  in_level_ff;

   // Result register: holds one response until the consumer takes it.
   logic                  out_valid_ff, out_valid_in;
   result_type            out_result_ff;

   logic                  req_accept;
   logic                  advance;

   // The logic stage runs whenever a request sits in the input register and
   // the result register is empty or is being emptied this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   esot_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   esot_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .opcode    (in_opcode_ff),
      .pin_level (in_level_ff),
      .cfg       (cfg),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_opcode_ff <= req_tuser;
         in_level_ff  <= req_tdata[0];
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.status;
   assign rsp_tdata  = {
      (RSP_TDATA_W - 2 * OUT_TIME_W - REASON_W - 2)'(0),
      out_result_ff.level_echo,
      out_result_ff.wake_record,
      out_result_ff.homing_flag,
      out_result_ff.fired_reason,
      out_result_ff.wake_time
   };

endmodule

// ===== design/esot_checker.sv =====
`timescale 1ns / 1ps

module esot_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [esot_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic [esot_pkg::STATUS_W-1:0]        rsp_tuser
);
   import esot_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // No response is pending in the first cycle after reset is released.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // The status code is always one of the defined outcomes.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_REPORT)
      else $error("undefined status code");

   // Only a reschedule carries a wake time, only a trigger carries a reason.
   a_wake_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_RESCHED |-> rsp_tdata[31:0] == '0
         && (rsp_tuser == ST_TRIG || rsp_tdata[39:32] == '0))
      else $error("wake time or reason set on wrong status");

   // Report fields are zero on every response but a state report.
   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_REPORT |-> rsp_tdata[79:40] == '0)
      else $error("report fields set on non-report response");

endmodule

bind endstop_oversample_trigger esot_checker u_esot_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
